// ===== rtl/core/ptw_pkg.sv =====
package ptw_pkg;

    localparam int unsigned LEVELS           = 4;
    localparam int unsigned INDEX_BITS       = 9;
    localparam int unsigned PAGE_OFFSET_BITS = 12;
    localparam int unsigned VIRT_W           = 48;
    localparam int unsigned ADDR_W           = 52;
    localparam int unsigned ENTRY_W          = 64;
    localparam int unsigned LEVEL_W          = 3;
    localparam int unsigned SHIFT_W          = 7;
    localparam int unsigned QUEUE_DEPTH      = 2;
    localparam int unsigned QUEUE_PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        MODE_REQUEST  = 1'b0,
        MODE_RESPONSE = 1'b1
    } mode_t;

    typedef enum logic
    {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } kind_t;

    // One classified input beat as it sits in the queue between front and back.
    typedef struct packed
    {
        logic                 is_resp;
        logic [VIRT_W-1:0]    virt;
        logic [ENTRY_W-1:0]   entry;
        logic [ADDR_W-1:0]    req_addr;
    } queue_entry_t;

    // Index bits of the virtual address for a level; levels count down to 1 at the leaf.
    // Indexes that fall above the virtual address width come out as zero.
    function automatic logic [INDEX_BITS-1:0] level_index(
        input logic [VIRT_W-1:0]  virt,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [LEVEL_W-1:0] lvl_m1;
        logic [SHIFT_W-1:0] sh;
        logic [ENTRY_W-1:0] ext;
        lvl_m1 = lvl - LEVEL_W'(1);
        sh     = SHIFT_W'(PAGE_OFFSET_BITS) + SHIFT_W'(lvl_m1) * SHIFT_W'(INDEX_BITS);
        ext    = ENTRY_W'(virt);
        return INDEX_BITS'(ext >> sh);
    endfunction

    // Address of the entry for a level inside the table whose frame is taken from bits 51..12.
    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [ADDR_W-1:0]  table_base,
        input logic [VIRT_W-1:0]  virt,
        input logic [LEVEL_W-1:0] lvl
    );
        return {table_base[ADDR_W-1:PAGE_OFFSET_BITS], level_index(virt, lvl), 3'b000};
    endfunction

endpackage

// ===== rtl/core/ptw_if.sv =====
interface ptw_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [ptw_pkg::VIRT_W-1:0]     virt_addr;
    logic [ptw_pkg::ENTRY_W-1:0]    entry_word;

    modport source (output valid, output mode, output virt_addr, output entry_word, input ready);
    modport sink   (input valid, input mode, input virt_addr, input entry_word, output ready);
endinterface

interface ptw_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [ptw_pkg::ADDR_W-1:0]     address;
    logic                           fault;

    modport source (output valid, output kind, output address, output fault, input ready);
    modport sink   (input valid, input kind, input address, input fault, output ready);
endinterface

interface ptw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ptw_pkg::ADDR_W-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ptw_front.sv =====
module ptw_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    ptw_in_if.sink                 in_ch,
    ptw_cfg_if.sink                cfg_ch,
    output logic                   push_valid,
    input  logic                   push_ready,
    output ptw_pkg::queue_entry_t  push_data
);

    logic [ptw_pkg::ADDR_W-1:0] root_reg;
    logic [ptw_pkg::ADDR_W-1:0] root_next;

    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        root_next = root_reg;
        if (cfg_ch.valid)
        begin
            root_next = cfg_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else
        begin
            root_reg <= root_next;
        end
    end

    // The top-level entry address is worked out here so the back end only
    // has to pick it up when it starts a walk.
    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;

    always_comb
    begin
        push_data.is_resp  = (ptw_pkg::mode_t'(in_ch.mode) == ptw_pkg::MODE_RESPONSE);
        push_data.virt     = in_ch.virt_addr;
        push_data.entry    = in_ch.entry_word;
        push_data.req_addr = ptw_pkg::entry_addr(root_reg, in_ch.virt_addr,
                                                 ptw_pkg::LEVEL_W'(ptw_pkg::LEVELS));
    end

endmodule

// ===== rtl/core/ptw_queue.sv =====
module ptw_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  ptw_pkg::queue_entry_t  push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output ptw_pkg::queue_entry_t  pop_data
);

    ptw_pkg::queue_entry_t              slots_reg [ptw_pkg::QUEUE_DEPTH];
    logic [ptw_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [ptw_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [ptw_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [ptw_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [ptw_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [ptw_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic                               do_push;
    logic                               do_pop;

    assign push_ready = (count_reg != ptw_pkg::QUEUE_CNT_W'(ptw_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ptw_pkg::QUEUE_PTR_W'(ptw_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ptw_pkg::QUEUE_PTR_W'(ptw_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/ptw_back.sv =====
module ptw_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  ptw_pkg::queue_entry_t  pop_data,
    ptw_out_if.source              out_ch
);

    logic                               busy_reg;
    logic                               busy_next;
    logic [ptw_pkg::LEVEL_W-1:0]        level_reg;
    logic [ptw_pkg::LEVEL_W-1:0]        level_next;
    logic [ptw_pkg::VIRT_W-1:0]         virt_reg;
    logic [ptw_pkg::VIRT_W-1:0]         virt_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    ptw_pkg::kind_t                     out_kind_reg;
    ptw_pkg::kind_t                     out_kind_next;
    logic [ptw_pkg::ADDR_W-1:0]         out_addr_reg;
    logic [ptw_pkg::ADDR_W-1:0]         out_addr_next;
    logic                               out_fault_reg;
    logic                               out_fault_next;
    logic                               do_pop;
    logic [ptw_pkg::LEVEL_W-1:0]        level_dn;

    // A beat leaves the queue whenever the output register is free or being drained,
    // including beats that are dropped without a result.
    assign pop_ready = !out_valid_reg || out_ch.ready;
    assign do_pop    = pop_valid && pop_ready;
    assign level_dn  = level_reg - 1'b1;

    always_comb
    begin
        busy_next      = busy_reg;
        level_next     = level_reg;
        virt_next      = virt_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_fault_next = out_fault_reg;
        if (do_pop)
        begin
            if (!pop_data.is_resp)
            begin
                if (!busy_reg)
                begin
                    busy_next      = 1'b1;
                    level_next     = ptw_pkg::LEVEL_W'(ptw_pkg::LEVELS);
                    virt_next      = pop_data.virt;
                    out_valid_next = 1'b1;
                    out_kind_next  = ptw_pkg::KIND_READ;
                    out_addr_next  = pop_data.req_addr;
                    out_fault_next = 1'b0;
                end
            end
            else if (busy_reg)
            begin
                out_valid_next = 1'b1;
                if (!pop_data.entry[0])
                begin
                    busy_next      = 1'b0;
                    level_next     = '0;
                    out_kind_next  = ptw_pkg::KIND_DONE;
                    out_addr_next  = '0;
                    out_fault_next = 1'b1;
                end
                else if (level_reg > ptw_pkg::LEVEL_W'(1))
                begin
                    level_next     = level_dn;
                    out_kind_next  = ptw_pkg::KIND_READ;
                    out_addr_next  = ptw_pkg::entry_addr(
                                         pop_data.entry[ptw_pkg::ADDR_W-1:0], virt_reg, level_dn);
                    out_fault_next = 1'b0;
                end
                else
                begin
                    busy_next      = 1'b0;
                    level_next     = '0;
                    out_kind_next  = ptw_pkg::KIND_DONE;
                    out_addr_next  = {pop_data.entry[ptw_pkg::ADDR_W-1:ptw_pkg::PAGE_OFFSET_BITS],
                                      virt_reg[ptw_pkg::PAGE_OFFSET_BITS-1:0]};
                    out_fault_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            level_reg     <= '0;
            virt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            level_reg     <= level_next;
            virt_reg      <= virt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_addr_reg  <= out_addr_next;
        out_fault_reg <= out_fault_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.kind    = out_kind_reg;
    assign out_ch.address = out_addr_reg;
    assign out_ch.fault   = out_fault_reg;

endmodule

// ===== rtl/core/page_table_walk_translate_core.sv =====
// A beat accepted into the queue is popped once the output register is free or being
// drained; the edge that pops it also loads its result (if any) into the output register.
// One input beat per cycle unless out_ch stalls, limited by the single back-end walk step.
// A two-entry queue separates input acceptance from the output register.
// Reset (rst_n, asynchronous, active low) clears the root base, the walk state and the queue.
module page_table_walk_translate_core
(
    input  logic        clk,
    input  logic        rst_n,
    ptw_in_if.sink      in_ch,
    ptw_out_if.source   out_ch,
    ptw_cfg_if.sink     cfg_ch
);

    logic                   push_valid;
    logic                   push_ready;
    ptw_pkg::queue_entry_t  push_data;
    logic                   pop_valid;
    logic                   pop_ready;
    ptw_pkg::queue_entry_t  pop_data;

    ptw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_ch     (cfg_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ptw_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ptw_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_ch     (out_ch)
    );

endmodule
